### rtl/wse_pkg.sv
// Shared types and constants for the WS2812 SPI pattern encoder.
// No dependencies.
`timescale 1ns / 1ps

package wse_pkg;

  localparam logic [4:0] SYM_MIN      = 5'd4;
  localparam logic [4:0] SYM_MAX      = 5'd16;
  localparam logic [5:0] TRL_MAX      = 6'd32;
  localparam logic [4:0] SYM_RESET    = 5'd11;
  localparam logic [4:0] HI1_RESET    = 5'd8;
  localparam logic [4:0] HI0_RESET    = 5'd3;
  localparam logic [5:0] TRL_RESET    = 6'd16;

  localparam logic [1:0] REG_SYM_LEN  = 2'd0;
  localparam logic [1:0] REG_ONE_HIGH = 2'd1;
  localparam logic [1:0] REG_ZERO_HI  = 2'd2;
  localparam logic [1:0] REG_TRAILER  = 2'd3;

  typedef struct packed {
    logic [7:0] color;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [4:0] sym;
    logic [4:0] hi1;
    logic [4:0] hi0;
    logic [5:0] trl;
  } cfg_t;

  typedef struct packed {
    logic busy;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BITS,
    BK_TRAIL
  } bk_state_t;

  typedef struct packed {
    logic [1:0] seg;
    logic [4:0] off;
  } sym_pos_t;

  // Splits a bit offset that may run up to two symbols past the current one.
  function automatic sym_pos_t split_pos(input logic [4:0] j, input logic [4:0] sym);
    sym_pos_t   p;
    logic [5:0] sym2;
    sym2 = {sym, 1'b0};
    if (j < sym) begin
      p.seg = 2'd0;
      p.off = j;
    end else if ({1'b0, j} < sym2) begin
      p.seg = 2'd1;
      p.off = 5'(j - sym);
    end else begin
      p.seg = 2'd2;
      p.off = 5'({1'b0, j} - sym2);
    end
    return p;
  endfunction

endpackage

### rtl/ws2812_spi_pattern_encoder_core.sv
// Top level of the WS2812 SPI pattern encoder: config registers, front queue
// and back-end packer. Depends on wse_pkg, wse_front and wse_back.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_ready, color_byte, frame_last | into block
//   output  | out_valid, out_ready, spi_byte, run_last   | out of block
//   config  | cfg_we, cfg_index, cfg_data                | into block
//
// The back end packs up to eight SPI bits a cycle while the output is free;
// an item gives symbol_length output bytes, as eight symbols always fill
// whole bytes. Queued items follow with no gap; an idle back end loads the
// item and packs from the cycle after; a frame end adds trailer_bytes bytes.
// Input is queued two deep, so input and output stall independently. Reset
// is synchronous; it empties queue and partial byte, loads register defaults.
`timescale 1ns / 1ps

module ws2812_spi_pattern_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] color_byte,
  input  logic       frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] spi_byte,
  output logic       run_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  logic [4:0] symbol_length;
  logic [4:0] one_high_length;
  logic [4:0] zero_high_length;
  logic [5:0] trailer_bytes;

  wse_pkg::cfg_t     cfg;
  wse_pkg::item_t    q_item;
  wse_pkg::bk_stat_t bk_stat;
  logic              q_valid;
  logic              q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_length    <= wse_pkg::SYM_RESET;
      one_high_length  <= wse_pkg::HI1_RESET;
      zero_high_length <= wse_pkg::HI0_RESET;
      trailer_bytes    <= wse_pkg::TRL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wse_pkg::REG_SYM_LEN:  symbol_length    <= cfg_data[4:0];
        wse_pkg::REG_ONE_HIGH: one_high_length  <= cfg_data[4:0];
        wse_pkg::REG_ZERO_HI:  zero_high_length <= cfg_data[4:0];
        wse_pkg::REG_TRAILER:  trailer_bytes    <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate register values to their usable ranges
  always_comb begin
    if (symbol_length < wse_pkg::SYM_MIN) cfg.sym = wse_pkg::SYM_MIN;
    else if (symbol_length > wse_pkg::SYM_MAX) cfg.sym = wse_pkg::SYM_MAX;
    else cfg.sym = symbol_length;
    cfg.hi1 = (one_high_length > cfg.sym) ? cfg.sym : one_high_length;
    cfg.hi0 = (zero_high_length > cfg.sym) ? cfg.sym : zero_high_length;
    if (trailer_bytes == 6'd0) cfg.trl = 6'd1;
    else if (trailer_bytes > wse_pkg::TRL_MAX) cfg.trl = wse_pkg::TRL_MAX;
    else cfg.trl = trailer_bytes;
  end

  wse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .color_byte (color_byte),
    .frame_last (frame_last),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  wse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .spi_byte  (spi_byte),
    .run_last  (run_last),
    .stat      (bk_stat)
  );

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid) else $error("queue popped while empty");

  a_accept_queues: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid) else $error("accepted item missing from queue");

  a_idle_loads: assert property (@(posedge clk) disable iff (rst)
    (!bk_stat.busy && q_valid) |-> q_ready) else $error("idle back end left item queued");
`endif

endmodule

### rtl/wse_front.sv
// Front end: accepts items and holds them in a two-entry queue.
// Depends on wse_pkg.
`timescale 1ns / 1ps

module wse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    color_byte,
  input  logic          frame_last,
  output logic          q_valid,
  input  logic          q_ready,
  output wse_pkg::item_t q_item
);

  wse_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].color <= color_byte;
      slots[wr_ptr].last  <= frame_last;
    end
  end

endmodule

### rtl/wse_back.sv
// Back end: expands queued bytes into SPI symbols, packs up to eight bits a
// cycle unless stalled and appends the frame trailer. Depends on wse_pkg.
`timescale 1ns / 1ps

module wse_back (
  input  logic              clk,
  input  logic              rst,
  input  wse_pkg::cfg_t     cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  wse_pkg::item_t    q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        spi_byte,
  output logic              run_last,
  output wse_pkg::bk_stat_t stat
);

  wse_pkg::bk_state_t state, state_next;
  logic [7:0] color, color_next;
  logic       last, last_next;
  logic [2:0] b, b_next;
  logic [4:0] i, i_next;
  logic [7:0] rem, rem_next;
  logic [2:0] pos, pos_next;
  logic [7:0] acc, acc_next;
  logic [5:0] tc, tc_next;
  logic       ov, ov_next;
  logic [7:0] obyte, obyte_next;
  logic       olast, olast_next;

  logic             out_free;
  logic [3:0]       take;
  logic [3:0]       n;
  logic             full;
  logic [7:0]       packed_acc;
  logic [7:0]       rem_after;
  wse_pkg::sym_pos_t kp;
  wse_pkg::sym_pos_t np;
  logic [3:0]       d;
  logic [4:0]       high;
  logic             finish;

  assign out_free  = !ov || out_ready;
  assign out_valid = ov;
  assign spi_byte  = obyte;
  assign run_last  = olast;
  assign stat.busy = (state != wse_pkg::BK_IDLE);

  assign take      = 4'({1'b0, pos} + 4'd1);
  assign full      = (rem >= {4'd0, take});
  assign n         = full ? take : rem[3:0];
  assign rem_after = 8'(rem - {4'd0, n});
  assign np        = wse_pkg::split_pos(5'(i + {1'b0, n}), cfg.sym);

  always_comb begin
    packed_acc = acc;
    for (int k = 0; k < 8; k++) begin
      kp   = wse_pkg::split_pos(5'(i + 5'(k)), cfg.sym);
      d    = 4'({1'b0, b} + {2'd0, kp.seg});
      high = color[3'd7 - d[2:0]] ? cfg.hi1 : cfg.hi0;
      if (4'(k) < n) packed_acc[3'(pos - 3'(k))] = (kp.off < high);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wse_pkg::BK_IDLE;
      ov    <= 1'b0;
      pos   <= 3'd7;
      acc   <= 8'd0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
      pos   <= pos_next;
      acc   <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    color <= color_next;
    last  <= last_next;
    b     <= b_next;
    i     <= i_next;
    rem   <= rem_next;
    tc    <= tc_next;
    obyte <= obyte_next;
    olast <= olast_next;
  end

  always_comb begin
    state_next = state;
    color_next = color;
    last_next  = last;
    b_next     = b;
    i_next     = i;
    rem_next   = rem;
    pos_next   = pos;
    acc_next   = acc;
    tc_next    = tc;
    ov_next    = ov && !out_ready;
    obyte_next = obyte;
    olast_next = olast;
    q_ready    = 1'b0;
    finish     = 1'b0;

    unique case (state)
      wse_pkg::BK_IDLE: begin
        finish = 1'b1;
      end
      wse_pkg::BK_BITS: begin
        if (out_free) begin
          rem_next = rem_after;
          b_next   = 3'({1'b0, b} + {2'd0, np.seg});
          i_next   = np.off;
          if (full) begin
            ov_next    = 1'b1;
            obyte_next = packed_acc;
            olast_next = !last && (rem_after < 8'd8);
            acc_next   = 8'd0;
            pos_next   = 3'd7;
          end else begin
            acc_next = packed_acc;
            pos_next = 3'(pos - n[2:0]);
          end
          if (rem_after == 8'd0) begin
            if (last) begin
              state_next = wse_pkg::BK_TRAIL;
              tc_next    = cfg.trl;
            end else begin
              finish = 1'b1;
            end
          end
        end
      end
      wse_pkg::BK_TRAIL: begin
        if (out_free) begin
          ov_next    = 1'b1;
          obyte_next = acc;
          olast_next = (tc == 6'd1);
          acc_next   = 8'd0;
          pos_next   = 3'd7;
          tc_next    = 6'(tc - 6'd1);
          if (tc == 6'd1) finish = 1'b1;
        end
      end
      default: begin
        state_next = wse_pkg::BK_IDLE;
      end
    endcase

    if (finish) begin
      if (q_valid) begin
        q_ready    = 1'b1;
        state_next = wse_pkg::BK_BITS;
        color_next = q_item.color;
        last_next  = q_item.last;
        b_next     = 3'd0;
        i_next     = 5'd0;
        rem_next   = {cfg.sym, 3'b000};
      end else begin
        state_next = wse_pkg::BK_IDLE;
      end
    end
  end

endmodule
